FILE: rtl/core/nsch_pkg.sv
package nsch_pkg;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] id;
    logic [15:0] prio;
    logic [15:0] burst;
  } sched_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [1:0] POLICY_FCFS = 2'd0;
  localparam logic [1:0] POLICY_SJF  = 2'd1;
  localparam logic [1:0] POLICY_PRIO = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

endpackage

FILE: rtl/core/nsch_queue.sv
module nsch_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  nsch_pkg::sched_op_t   push_op_i,
  input  logic                  pop_i,
  output nsch_pkg::sched_op_t   head_op_o,
  output nsch_pkg::q_stat_t     stat_o
);

  nsch_pkg::sched_op_t slot_q [nsch_pkg::QUEUE_DEPTH];

  logic [nsch_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [nsch_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [nsch_pkg::QPTR_W:0]   fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign head_op_o    = slot_q[rd_ptr_q];
  assign stat_o.full  = (fill_q == (nsch_pkg::QPTR_W+1)'(nsch_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (fill_q == '0);

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i || pop_i)
    else $error("push into full queue");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (nsch_pkg::QPTR_W+1)'(nsch_pkg::QUEUE_DEPTH))
    else $error("queue fill out of range");
`endif

endmodule

FILE: rtl/core/nsch_front.sv
module nsch_front #(
  parameter int unsigned MAX_PROCS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  kind_i,
  input  logic [15:0]           proc_id_i,
  input  logic [15:0]           proc_priority_i,
  input  logic [15:0]           proc_burst_i,
  input  nsch_pkg::q_stat_t     q_stat_i,
  output logic                  busy,
  output logic                  push_o,
  output nsch_pkg::sched_op_t   push_op_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  logic [CNT_W-1:0] add_cnt_q, add_cnt_d;
  logic             accept;
  logic             is_tick;
  logic             room;

  assign busy    = q_stat_i.full;
  assign accept  = start && !q_stat_i.full;
  assign is_tick = (kind_i == 1'b1);
  assign room    = (add_cnt_q < CNT_W'(MAX_PROCS));

  // drop adds once the table is full
  assign push_o = accept && (is_tick || room);

  always_comb begin
    push_op_o       = '0;
    push_op_o.kind  = is_tick ? nsch_pkg::OP_TICK : nsch_pkg::OP_ADD;
    if (!is_tick) begin
      push_op_o.id    = proc_id_i;
      push_op_o.prio  = proc_priority_i;
      push_op_o.burst = proc_burst_i;
    end
  end

  always_comb begin
    add_cnt_d = add_cnt_q;
    if (push_o && !is_tick) begin
      add_cnt_d = add_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_cnt_q <= '0;
    end else begin
      add_cnt_q <= add_cnt_d;
    end
  end

endmodule

FILE: rtl/core/nsch_back.sv
module nsch_back #(
  parameter int unsigned MAX_PROCS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  nsch_pkg::sched_op_t   head_op_i,
  input  nsch_pkg::q_stat_t     q_stat_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  output logic [31:0]           tick_time_o,
  output logic [15:0]           running_id_o,
  output logic                  idle_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [15:0] id_mem    [MAX_PROCS];
  logic [15:0] prio_mem  [MAX_PROCS];
  logic [15:0] burst_mem [MAX_PROCS];
  logic        done_mem  [MAX_PROCS];

  logic [1:0]       state_q, state_d;
  logic [1:0]       policy_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [31:0]      time_q, time_d;

  logic             run_busy_q, run_busy_d;
  logic [IDX_W-1:0] run_idx_q, run_idx_d;
  logic [15:0]      run_id_q, run_id_d;
  logic [15:0]      run_burst_q, run_burst_d;
  logic [31:0]      run_start_q, run_start_d;

  logic             found_q, found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [15:0]      best_key_q, best_key_d;
  logic [15:0]      best_id_q, best_id_d;
  logic [15:0]      best_burst_q, best_burst_d;

  logic             rv_q, rv_d;
  logic [IDX_W-1:0] rd_idx_q;
  logic [15:0]      rd_id_q, rd_prio_q, rd_burst_q;
  logic             rd_done_q;
  logic             rd_en;

  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_time_q, out_time_d;
  logic [15:0]      out_id_q, out_id_d;
  logic             out_idle_q, out_idle_d;

  logic             add_we;
  logic             done_we;
  logic [IDX_W-1:0] done_waddr;
  logic             done_wdata;

  logic [31:0]      elapsed;
  logic             retire;
  logic             still_run;
  logic [15:0]      rd_key;
  logic             take;

  assign elapsed   = time_q - run_start_q;
  assign retire    = run_busy_q && (elapsed >= {16'b0, run_burst_q});
  assign still_run = run_busy_q && !retire;

  always_comb begin
    case (policy_q)
      nsch_pkg::POLICY_SJF:  rd_key = rd_burst_q;
      nsch_pkg::POLICY_PRIO: rd_key = rd_prio_q;
      default:               rd_key = '0;
    endcase
  end

  assign take = rv_q && !rd_done_q && (!found_q || (rd_key < best_key_q));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    time_d       = time_q;
    run_busy_d   = run_busy_q;
    run_idx_d    = run_idx_q;
    run_id_d     = run_id_q;
    run_burst_d  = run_burst_q;
    run_start_d  = run_start_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    best_id_d    = best_id_q;
    best_burst_d = best_burst_q;
    rv_d         = 1'b0;
    rd_en        = 1'b0;
    pop_o        = 1'b0;
    add_we       = 1'b0;
    done_we      = 1'b0;
    done_waddr   = count_q[IDX_W-1:0];
    done_wdata   = 1'b0;
    out_valid_d  = 1'b0;
    out_time_d   = out_time_q;
    out_id_d     = out_id_q;
    out_idle_d   = out_idle_q;

    if (take) begin
      found_d      = 1'b1;
      best_idx_d   = rd_idx_q;
      best_key_d   = rd_key;
      best_id_d    = rd_id_q;
      best_burst_d = rd_burst_q;
    end

    case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (head_op_i.kind == nsch_pkg::OP_ADD) begin
            if (count_q < CNT_W'(MAX_PROCS)) begin
              add_we  = 1'b1;
              done_we = 1'b1;
              count_d = count_q + 1'b1;
            end
          end else begin
            if (retire) begin
              done_we    = 1'b1;
              done_waddr = run_idx_q;
              done_wdata = 1'b1;
            end
            run_busy_d = still_run;
            if (still_run || (count_q == '0)) begin
              out_valid_d = 1'b1;
              out_time_d  = time_q;
              out_id_d    = still_run ? run_id_q : 16'd0;
              out_idle_d  = !still_run;
              time_d      = time_q + 1'b1;
            end else begin
              scan_d  = '0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        rd_en  = 1'b1;
        rv_d   = 1'b1;
        scan_d = scan_q + 1'b1;
        if ((scan_q + CNT_W'(1)) == count_q) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (found_q) begin
          run_busy_d  = 1'b1;
          run_idx_d   = best_idx_q;
          run_id_d    = best_id_q;
          run_burst_d = best_burst_q;
          run_start_d = time_q;
        end
        out_valid_d = 1'b1;
        out_time_d  = time_q;
        out_id_d    = found_q ? best_id_q : 16'd0;
        out_idle_d  = !found_q;
        time_d      = time_q + 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= nsch_pkg::POLICY_FCFS;
      count_q     <= '0;
      scan_q      <= '0;
      time_q      <= '0;
      run_busy_q  <= 1'b0;
      run_idx_q   <= '0;
      found_q     <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_time_q  <= '0;
      out_id_q    <= '0;
      out_idle_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      scan_q      <= scan_d;
      time_q      <= time_d;
      run_busy_q  <= run_busy_d;
      run_idx_q   <= run_idx_d;
      found_q     <= found_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
      out_time_q  <= out_time_d;
      out_id_q    <= out_id_d;
      out_idle_q  <= out_idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_id_q     <= run_id_d;
    run_burst_q  <= run_burst_d;
    run_start_q  <= run_start_d;
    best_idx_q   <= best_idx_d;
    best_key_q   <= best_key_d;
    best_id_q    <= best_id_d;
    best_burst_q <= best_burst_d;
  end

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      id_mem[count_q[IDX_W-1:0]]    <= head_op_i.id;
      prio_mem[count_q[IDX_W-1:0]]  <= head_op_i.prio;
      burst_mem[count_q[IDX_W-1:0]] <= head_op_i.burst;
    end
    if (rd_en) begin
      rd_id_q    <= id_mem[scan_q[IDX_W-1:0]];
      rd_prio_q  <= prio_mem[scan_q[IDX_W-1:0]];
      rd_burst_q <= burst_mem[scan_q[IDX_W-1:0]];
      rd_idx_q   <= scan_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_we) begin
      done_mem[done_waddr] <= done_wdata;
    end
    if (rd_en) begin
      rd_done_q <= done_mem[scan_q[IDX_W-1:0]];
    end
  end

  assign result_valid_o = out_valid_q;
  assign tick_time_o    = out_time_q;
  assign running_id_o   = out_id_q;
  assign idle_o         = out_idle_q;

`ifndef NO_ASSERTIONS
  a_idle_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_idle_q |-> out_id_q == 16'd0)
    else $error("idle result carries an id");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PROCS))
    else $error("table count out of range");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> scan_q < count_q)
    else $error("scan beyond table");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_stat_i.empty)
    else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/nonpreemptive_cpu_scheduler_unit.sv
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      kind_i, proc_id_i, proc_priority_i,
//                                                proc_burst_i
// result    out        result_valid_o, 1 cycle   tick_time_o, running_id_o, idle_o
// config    in         cfg_we_i                  cfg_wdata_i (policy_mode)
//
// An add, and a tick while a job keeps running, are each handled in S_IDLE without a scan.
// A tick that must select scans the table through one memory read port, stepping through
// S_SCAN, S_LAST and S_FIN before its result is registered.
// A four-entry queue decouples intake from execution; busy is high while it is full.
// Reset is asynchronous, active low, and needs no clearing pass.
// Results cannot be stalled by the receiver.
module nonpreemptive_cpu_scheduler_unit #(
  parameter int unsigned MAX_PROCS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] proc_id_i,
  input  logic [15:0] proc_priority_i,
  input  logic [15:0] proc_burst_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [31:0] tick_time_o,
  output logic [15:0] running_id_o,
  output logic        idle_o
);

  logic                push;
  logic                pop;
  nsch_pkg::sched_op_t push_op;
  nsch_pkg::sched_op_t head_op;
  nsch_pkg::q_stat_t   q_stat;

  nsch_front #(
    .MAX_PROCS(MAX_PROCS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (kind_i),
    .proc_id_i      (proc_id_i),
    .proc_priority_i(proc_priority_i),
    .proc_burst_i   (proc_burst_i),
    .q_stat_i       (q_stat),
    .busy           (busy),
    .push_o         (push),
    .push_op_o      (push_op)
  );

  nsch_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .pop_i    (pop),
    .head_op_o(head_op),
    .stat_o   (q_stat)
  );

  nsch_back #(
    .MAX_PROCS(MAX_PROCS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_op_i     (head_op),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .tick_time_o   (tick_time_o),
    .running_id_o  (running_id_o),
    .idle_o        (idle_o)
  );

endmodule
